[hw/rtl/pfde_pkg.sv]
// ----------------------------------------------------------------------------
// Page framebuffer draw engine package
// Command codes and fixed field widths shared by the interfaces and the engine.
// ----------------------------------------------------------------------------
package pfde_pkg;

  localparam int unsigned CMD_W     = 3;
  localparam int unsigned XA_W      = 7;
  localparam int unsigned YA_W      = 6;
  localparam int unsigned XB_W      = 8;
  localparam int unsigned YB_W      = 7;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned COORD_W   = 9;

  typedef logic [CMD_W-1:0]   cmd_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [BYTE_W-1:0]  byte_t;

  localparam cmd_t CMD_SET_DOT = 3'd0;
  localparam cmd_t CMD_CLR_DOT = 3'd1;
  localparam cmd_t CMD_LINE    = 3'd2;
  localparam cmd_t CMD_RECT    = 3'd3;
  localparam cmd_t CMD_FILL    = 3'd4;
  localparam cmd_t CMD_READ    = 3'd5;

endpackage

[hw/rtl/pfde_intf.sv]
// ----------------------------------------------------------------------------
// Page framebuffer draw engine channels
// Valid/ready command and result channels with their payload fields.
// ----------------------------------------------------------------------------
interface pfde_in_if;
  import pfde_pkg::*;

  logic              valid;
  logic              ready;
  cmd_t              cmd;
  logic [XA_W-1:0]   x_a;
  logic [YA_W-1:0]   y_a;
  logic [XB_W-1:0]   x_b;
  logic [YB_W-1:0]   y_b;
  byte_t             pattern;

  modport source (output valid, cmd, x_a, y_a, x_b, y_b, pattern, input ready);
  modport sink (input valid, cmd, x_a, y_a, x_b, y_b, pattern, output ready);
endinterface

interface pfde_out_if;
  import pfde_pkg::*;

  logic  valid;
  logic  ready;
  byte_t read_data;
  logic  bit_changed;

  modport source (output valid, read_data, bit_changed, input ready);
  modport sink (input valid, read_data, bit_changed, output ready);
endinterface

[hw/rtl/page_framebuffer_draw_engine_unit.sv]
// ----------------------------------------------------------------------------
// Page framebuffer draw engine
// Dot, line, rectangle, page fill and byte read commands over a one-bit frame
// memory stored as pages of column bytes.
// ----------------------------------------------------------------------------
// Usage: commands arrive on in_if and each transaction yields exactly one
// result transaction on out_if. in_if.ready is high only while the engine is
// idle; one command is worked at a time by a small sequencer around the
// single-port frame memory, whose read-modify-write sets the pace.
// Dots, lines and rectangles read, modify and write back each pixel on the
// display, and a line steps past its clipped dots; a read fetches one byte,
// a page fill writes each byte directly and empty commands go to the result.
// The result waits in an output register; the engine takes the next command
// while it waits and stalls only when a second result is ready before the
// first has been taken.
// After reset the frame memory is cleared one byte per cycle, all
// DISPLAY_WIDTH * ceil(DISPLAY_HEIGHT / 8) bytes (1024 by default); no
// command is accepted during that pass.
// ----------------------------------------------------------------------------
module page_framebuffer_draw_engine_unit #(
  parameter int DISPLAY_WIDTH  = 128,
  parameter int DISPLAY_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pfde_in_if.sink     in_if,
  pfde_out_if.source  out_if
);
  import pfde_pkg::*;

  localparam int PAGE_COUNT = (DISPLAY_HEIGHT + 7) / 8;
  localparam int MEM_SIZE   = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int AW         = $clog2(MEM_SIZE);
  localparam int CW         = $clog2(DISPLAY_WIDTH);
  localparam int PW         = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam coord_t WLIM   = COORD_W'(DISPLAY_WIDTH);
  localparam coord_t HLIM   = COORD_W'(DISPLAY_HEIGHT);
  localparam coord_t PLIM   = COORD_W'(PAGE_COUNT);
  localparam logic [AW-1:0] CLR_LAST = AW'(MEM_SIZE - 1);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PLOT,
    ST_MODIFY,
    ST_FILL,
    ST_READ,
    ST_RESULT
  } state_e;

  state_e          state_q, state_d;
  cmd_t            cmd_q, cmd_d;
  logic            xmaj_q, xmaj_d;
  coord_t          maj_q, maj_d;
  coord_t          min_q, min_d;
  coord_t          maj_start_q, maj_start_d;
  coord_t          maj_lim_q, maj_lim_d;
  coord_t          min_lim_q, min_lim_d;
  coord_t          dmaj_q, dmaj_d;
  coord_t          dmin_q, dmin_d;
  coord_t          acc_q, acc_d;
  logic            neg_q, neg_d;
  logic            changed_q, changed_d;
  logic            rd_ok_q, rd_ok_d;
  byte_t           pattern_q, pattern_d;
  logic [AW-1:0]   clr_q, clr_d;
  logic            out_valid_q, out_valid_d;
  byte_t           out_data_q, out_data_d;
  logic            out_changed_q, out_changed_d;

  byte_t           frame_mem [MEM_SIZE];
  byte_t           rdata_q;
  logic            mem_we, mem_re;
  logic [AW-1:0]   pix_addr, mem_waddr;
  byte_t           mem_wdata;

  coord_t          px, py;
  logic            on_disp;
  logic [CW-1:0]   col_idx;
  logic [PW-1:0]   page_idx;
  byte_t           bit_mask, new_byte;
  logic            pix_set;

  coord_t          adv_maj, adv_min, adv_acc;
  logic            adv_done;
  coord_t          maj_inc, min_inc;
  logic [COORD_W:0] acc_sum;
  logic            acc_wrap;

  coord_t          xa9, ya9, xb9, yb9, dx, dy, sx, sy, ex, ey;
  coord_t          rect_xe, rect_ye, rect_xl, rect_yl, fill_xl, fill_pl;
  logic            line_xm, line_swap;
  logic            accept;

  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == ST_IDLE);
  assign out_if.valid = out_valid_q;
  assign out_if.read_data = out_data_q;
  assign out_if.bit_changed = out_changed_q;

  // Pixel position and its frame memory address.
  always_comb begin
    px       = xmaj_q ? maj_q : min_q;
    py       = xmaj_q ? min_q : maj_q;
    on_disp  = (px < WLIM) && (py < HLIM);
    col_idx  = px[CW-1:0];
    page_idx = (cmd_q == CMD_FILL) ? min_q[PW-1:0] : py[PW+2:3];
    pix_addr = AW'(col_idx) * AW'(PAGE_COUNT) + AW'(page_idx);
    bit_mask = byte_t'(1) << py[2:0];
    pix_set  = (cmd_q != CMD_CLR_DOT);
    new_byte = pix_set ? (rdata_q | bit_mask) : (rdata_q & ~bit_mask);
  end

  // Step to the next pixel of the current command.
  always_comb begin
    maj_inc  = maj_q + 1'b1;
    min_inc  = min_q + 1'b1;
    acc_sum  = {1'b0, acc_q} + {1'b0, dmin_q};
    acc_wrap = acc_sum >= {1'b0, dmaj_q};
    adv_maj  = maj_q;
    adv_min  = min_q;
    adv_acc  = acc_q;
    adv_done = 1'b1;
    case (cmd_q)
      CMD_LINE: begin
        adv_maj  = maj_inc;
        adv_acc  = acc_wrap ? COORD_W'(acc_sum - {1'b0, dmaj_q}) : acc_sum[COORD_W-1:0];
        if (acc_wrap) begin
          adv_min = neg_q ? (min_q - 1'b1) : min_inc;
        end
        adv_done = maj_inc >= maj_lim_q;
      end
      CMD_RECT, CMD_FILL: begin
        if (maj_inc < maj_lim_q) begin
          adv_maj  = maj_inc;
          adv_done = 1'b0;
        end else begin
          adv_maj  = maj_start_q;
          adv_min  = min_inc;
          adv_done = min_inc >= min_lim_q;
        end
      end
      default: begin
        adv_done = 1'b1;
      end
    endcase
  end

  // Command setup from the input fields.
  always_comb begin
    xa9       = COORD_W'(in_if.x_a);
    ya9       = COORD_W'(in_if.y_a);
    xb9       = COORD_W'(in_if.x_b);
    yb9       = COORD_W'(in_if.y_b);
    dx        = (xb9 >= xa9) ? (xb9 - xa9) : (xa9 - xb9);
    dy        = (yb9 >= ya9) ? (yb9 - ya9) : (ya9 - yb9);
    line_xm   = dx >= dy;
    line_swap = line_xm ? (xa9 > xb9) : (ya9 > yb9);
    sx        = line_swap ? xb9 : xa9;
    sy        = line_swap ? yb9 : ya9;
    ex        = line_swap ? xa9 : xb9;
    ey        = line_swap ? ya9 : yb9;
    rect_xe   = xa9 + xb9;
    rect_ye   = ya9 + yb9;
    rect_xl   = (rect_xe < WLIM) ? rect_xe : WLIM;
    rect_yl   = (rect_ye < HLIM) ? rect_ye : HLIM;
    fill_xl   = (xb9 < WLIM) ? xb9 : WLIM;
    fill_pl   = (yb9 < PLIM) ? yb9 : PLIM;
  end

  // Sequencer.
  always_comb begin
    state_d       = state_q;
    cmd_d         = cmd_q;
    xmaj_d        = xmaj_q;
    maj_d         = maj_q;
    min_d         = min_q;
    maj_start_d   = maj_start_q;
    maj_lim_d     = maj_lim_q;
    min_lim_d     = min_lim_q;
    dmaj_d        = dmaj_q;
    dmin_d        = dmin_q;
    acc_d         = acc_q;
    neg_d         = neg_q;
    changed_d     = changed_q;
    rd_ok_d       = rd_ok_q;
    pattern_d     = pattern_q;
    clr_d         = clr_q;
    out_valid_d   = out_valid_q && !out_if.ready;
    out_data_d    = out_data_q;
    out_changed_d = out_changed_q;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_wdata     = new_byte;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == CLR_LAST) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_d       = in_if.cmd;
          pattern_d   = in_if.pattern;
          xmaj_d      = 1'b1;
          maj_d       = xa9;
          min_d       = ya9;
          maj_start_d = xa9;
          acc_d       = '0;
          changed_d   = 1'b0;
          rd_ok_d     = (xa9 < WLIM) && (ya9 < HLIM);
          case (in_if.cmd)
            CMD_SET_DOT, CMD_CLR_DOT: begin
              state_d = ST_PLOT;
            end
            CMD_LINE: begin
              xmaj_d    = line_xm;
              maj_d     = line_xm ? sx : sy;
              min_d     = line_xm ? sy : sx;
              maj_lim_d = line_xm ? ex : ey;
              neg_d     = line_xm ? (ey < sy) : (ex < sx);
              dmaj_d    = line_xm ? dx : dy;
              dmin_d    = line_xm ? dy : dx;
              state_d   = ((dx == '0) && (dy == '0)) ? ST_RESULT : ST_PLOT;
            end
            CMD_RECT: begin
              maj_lim_d = rect_xl;
              min_lim_d = rect_yl;
              state_d   = ((xa9 >= rect_xl) || (ya9 >= rect_yl)) ? ST_RESULT : ST_PLOT;
            end
            CMD_FILL: begin
              maj_lim_d = fill_xl;
              min_lim_d = fill_pl;
              state_d   = ((xa9 >= fill_xl) || (ya9 >= fill_pl)) ? ST_RESULT : ST_FILL;
            end
            CMD_READ: begin
              state_d = ST_READ;
            end
            default: begin
              state_d = ST_RESULT;
            end
          endcase
        end
      end
      ST_PLOT: begin
        if (on_disp) begin
          mem_re  = 1'b1;
          state_d = ST_MODIFY;
        end else begin
          maj_d   = adv_maj;
          min_d   = adv_min;
          acc_d   = adv_acc;
          state_d = adv_done ? ST_RESULT : ST_PLOT;
        end
      end
      ST_MODIFY: begin
        mem_we = 1'b1;
        if ((cmd_q == CMD_SET_DOT) || (cmd_q == CMD_CLR_DOT)) begin
          changed_d = new_byte != rdata_q;
        end
        maj_d   = adv_maj;
        min_d   = adv_min;
        acc_d   = adv_acc;
        state_d = adv_done ? ST_RESULT : ST_PLOT;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = pattern_q;
        maj_d     = adv_maj;
        min_d     = adv_min;
        state_d   = adv_done ? ST_RESULT : ST_FILL;
      end
      ST_READ: begin
        mem_re  = rd_ok_q;
        state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (!out_valid_q || out_if.ready) begin
          out_valid_d   = 1'b1;
          out_data_d    = ((cmd_q == CMD_READ) && rd_ok_q) ? rdata_q : '0;
          out_changed_d = changed_q;
          state_d       = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : pix_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      cmd_q         <= CMD_SET_DOT;
      xmaj_q        <= 1'b1;
      maj_q         <= '0;
      min_q         <= '0;
      maj_start_q   <= '0;
      maj_lim_q     <= '0;
      min_lim_q     <= '0;
      dmaj_q        <= '0;
      dmin_q        <= '0;
      acc_q         <= '0;
      neg_q         <= 1'b0;
      changed_q     <= 1'b0;
      rd_ok_q       <= 1'b0;
      pattern_q     <= '0;
      clr_q         <= '0;
      out_valid_q   <= 1'b0;
      out_data_q    <= '0;
      out_changed_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      cmd_q         <= cmd_d;
      xmaj_q        <= xmaj_d;
      maj_q         <= maj_d;
      min_q         <= min_d;
      maj_start_q   <= maj_start_d;
      maj_lim_q     <= maj_lim_d;
      min_lim_q     <= min_lim_d;
      dmaj_q        <= dmaj_d;
      dmin_q        <= dmin_d;
      acc_q         <= acc_d;
      neg_q         <= neg_d;
      changed_q     <= changed_d;
      rd_ok_q       <= rd_ok_d;
      pattern_q     <= pattern_d;
      clr_q         <= clr_d;
      out_valid_q   <= out_valid_d;
      out_data_q    <= out_data_d;
      out_changed_q <= out_changed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= frame_mem[pix_addr];
    end
  end

  // The clearing pass must finish before any command is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_if.ready)
    else $error("command accepted during the clearing pass");

  // The line accumulator stays below the major delta between steps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_PLOT) && (cmd_q == CMD_LINE)) |-> (acc_q < dmaj_q))
    else $error("line accumulator out of range");

  // A new result only appears out of the result state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESULT))
    else $error("result raised outside the result state");

  // One command at a time: the engine is busy right after a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_if.ready)
    else $error("engine still ready after taking a command");

endmodule

[tb/sv/tb_page_framebuffer_draw_engine_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page framebuffer draw engine testbench
// Drives dot, line, rectangle, page fill, read and unused commands into the
// engine under shifting idle patterns and a long result stall. A shadow frame
// memory predicts every result, and each result transaction is checked in order.
// ----------------------------------------------------------------------------
module tb_page_framebuffer_draw_engine_unit;
  import pfde_pkg::*;

  localparam int DISPLAY_WIDTH  = 128;
  localparam int DISPLAY_HEIGHT = 64;
  localparam int PAGE_COUNT     = (DISPLAY_HEIGHT + 7) / 8;
  localparam int FRAME_BYTES    = DISPLAY_WIDTH * PAGE_COUNT;
  localparam int LONG_STALL     = 200;
  localparam int LATENCY_SLACK  = 64;
  localparam int MAX_MISMATCH_REPORTS = 10;
  localparam longint RUN_LIMIT_NS = 8_000_000;

  localparam cmd_t CMD_UNUSED_LO = 3'd6;
  localparam cmd_t CMD_UNUSED_HI = 3'd7;

  typedef struct {
    cmd_t            cmd;
    logic [XA_W-1:0] x_a;
    logic [YA_W-1:0] y_a;
    logic [XB_W-1:0] x_b;
    logic [YB_W-1:0] y_b;
    byte_t           pattern;
  } draw_cmd_t;

  typedef struct {
    byte_t read_data;
    logic  bit_changed;
  } draw_reply_t;

  logic clk_i;
  logic rst_ni;

  pfde_in_if  cmd_if ();
  pfde_out_if rsp_if ();

  page_framebuffer_draw_engine_unit #(
    .DISPLAY_WIDTH (DISPLAY_WIDTH),
    .DISPLAY_HEIGHT(DISPLAY_HEIGHT)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (cmd_if),
    .out_if(rsp_if)
  );

  byte_t       frame_model [FRAME_BYTES];
  draw_cmd_t   cmd_backlog [$];
  draw_reply_t pending_replies [$];
  draw_cmd_t   cmd_on_bus;
  draw_cmd_t   cmd_to_offer;
  bit          offer_now;
  draw_reply_t reply_due;

  int send_idle_pct;
  int recv_idle_pct;
  bit stall_request;
  int stall_left;
  int long_stalls;
  int big_rects;
  int mismatch_count;
  int replies_checked;
  int cmd_tally [8];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("page_framebuffer_draw_engine_unit verification failed");
    $finish;
  end

  function automatic bit plot_dot(int x, int y, bit on);
    int    idx;
    byte_t mask;
    byte_t old_byte;
    byte_t new_byte;
    if (x < 0 || y < 0 || x >= DISPLAY_WIDTH || y >= DISPLAY_HEIGHT) return 1'b0;
    idx      = x * PAGE_COUNT + y / 8;
    mask     = 8'h01 << (y % 8);
    old_byte = frame_model[idx];
    new_byte = on ? (old_byte | mask) : (old_byte & ~mask);
    frame_model[idx] = new_byte;
    return new_byte != old_byte;
  endfunction

  function automatic void trace_line(int x0, int y0, int x1, int y1);
    int dx;
    int dy;
    int acc;
    int step;
    int t;
    dx  = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy  = (y1 > y0) ? y1 - y0 : y0 - y1;
    acc = 0;
    if (dx == 0 && dy == 0) return;
    if (dx >= dy) begin
      if (x0 > x1) begin
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
      end
      step = (y1 >= y0) ? 1 : -1;
      while (x0 < x1) begin
        void'(plot_dot(x0, y0, 1'b1));
        x0++;
        acc += dy;
        if (acc >= dx) begin
          acc -= dx;
          y0 += step;
        end
      end
    end else begin
      if (y0 > y1) begin
        t = x0; x0 = x1; x1 = t;
        t = y0; y0 = y1; y1 = t;
      end
      step = (x1 >= x0) ? 1 : -1;
      while (y0 < y1) begin
        void'(plot_dot(x0, y0, 1'b1));
        y0++;
        acc += dx;
        if (acc >= dy) begin
          acc -= dy;
          x0 += step;
        end
      end
    end
  endfunction

  function automatic draw_reply_t apply_draw_cmd(draw_cmd_t c);
    draw_reply_t reply;
    int          row;
    int          col;
    int          row_end;
    int          col_end;
    reply.read_data   = '0;
    reply.bit_changed = 1'b0;
    case (c.cmd)
      CMD_SET_DOT, CMD_CLR_DOT: begin
        reply.bit_changed = plot_dot(int'(c.x_a), int'(c.y_a), c.cmd == CMD_SET_DOT);
      end
      CMD_LINE: begin
        trace_line(int'(c.x_a), int'(c.y_a), int'(c.x_b), int'(c.y_b));
      end
      CMD_RECT: begin
        row_end = int'(c.y_a) + int'(c.y_b);
        col_end = int'(c.x_a) + int'(c.x_b);
        for (row = int'(c.y_a); row < row_end && row < DISPLAY_HEIGHT; row++) begin
          for (col = int'(c.x_a); col < col_end && col < DISPLAY_WIDTH; col++) begin
            void'(plot_dot(col, row, 1'b1));
          end
        end
      end
      CMD_FILL: begin
        for (row = int'(c.y_a); row < int'(c.y_b) && row < PAGE_COUNT; row++) begin
          for (col = int'(c.x_a); col < int'(c.x_b) && col < DISPLAY_WIDTH; col++) begin
            frame_model[col * PAGE_COUNT + row] = c.pattern;
          end
        end
      end
      CMD_READ: begin
        if (c.x_a < DISPLAY_WIDTH && c.y_a < DISPLAY_HEIGHT) begin
          reply.read_data = frame_model[int'(c.x_a) * PAGE_COUNT + int'(c.y_a) / 8];
        end
      end
      default: begin
      end
    endcase
    return reply;
  endfunction

  // Command driver: holds the offered command until the engine takes it.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid   <= 1'b0;
      cmd_if.cmd     <= '0;
      cmd_if.x_a     <= '0;
      cmd_if.y_a     <= '0;
      cmd_if.x_b     <= '0;
      cmd_if.y_b     <= '0;
      cmd_if.pattern <= '0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        pending_replies.push_back(apply_draw_cmd(cmd_on_bus));
        cmd_tally[cmd_on_bus.cmd]++;
      end
      if (!cmd_if.valid || cmd_if.ready) begin
        offer_now = cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct;
        if (offer_now) begin
          cmd_to_offer   = cmd_backlog.pop_front();
          cmd_on_bus     = cmd_to_offer;
          cmd_if.cmd     <= cmd_to_offer.cmd;
          cmd_if.x_a     <= cmd_to_offer.x_a;
          cmd_if.y_a     <= cmd_to_offer.y_a;
          cmd_if.x_b     <= cmd_to_offer.x_b;
          cmd_if.y_b     <= cmd_to_offer.y_b;
          cmd_if.pattern <= cmd_to_offer.pattern;
        end
        cmd_if.valid <= offer_now;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left <= 0;
    end else if (stall_request && stall_left == 0) begin
      stall_left <= LONG_STALL;
      long_stalls++;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= (stall_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result monitor: every result transaction is matched against the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_MISMATCH_REPORTS) begin
          $display("%0t: unexpected result read_data %02h bit_changed %0b",
                   $realtime, rsp_if.read_data, rsp_if.bit_changed);
        end
      end else begin
        reply_due = pending_replies.pop_front();
        replies_checked++;
        if (rsp_if.read_data !== reply_due.read_data ||
            rsp_if.bit_changed !== reply_due.bit_changed) begin
          mismatch_count++;
          if (mismatch_count <= MAX_MISMATCH_REPORTS) begin
            $display("%0t: result %0d expected read_data %02h bit_changed %0b, got %02h %0b",
                     $realtime, replies_checked, reply_due.read_data,
                     reply_due.bit_changed, rsp_if.read_data, rsp_if.bit_changed);
          end
        end
      end
    end
  end

  task automatic queue_cmd(cmd_t cmd, int xa, int ya, int xb, int yb, int pat);
    draw_cmd_t c;
    c.cmd     = cmd;
    c.x_a     = XA_W'(xa);
    c.y_a     = YA_W'(ya);
    c.x_b     = XB_W'(xb);
    c.y_b     = YB_W'(yb);
    c.pattern = BYTE_W'(pat);
    cmd_backlog.push_back(c);
  endtask

  task automatic queue_random_cmd();
    int   pick;
    cmd_t cmd;
    int   xa;
    int   ya;
    int   xb;
    int   yb;
    int   pat;
    pick = $urandom_range(99);
    xa   = $urandom_range(127);
    ya   = $urandom_range(63);
    xb   = $urandom_range(255);
    yb   = $urandom_range(127);
    pat  = $urandom_range(255);
    if (pick < 18) cmd = CMD_SET_DOT;
    else if (pick < 30) cmd = CMD_CLR_DOT;
    else if (pick < 52) cmd = CMD_READ;
    else if (pick < 68) cmd = CMD_LINE;
    else if (pick < 80) cmd = CMD_RECT;
    else if (pick < 94) cmd = CMD_FILL;
    else cmd = pick[0] ? CMD_UNUSED_LO : CMD_UNUSED_HI;
    case (cmd)
      CMD_LINE: begin
        if ($urandom_range(2) != 0) begin
          xb = xa + $urandom_range(48) - 24;
          yb = ya + $urandom_range(48) - 24;
          if (xb < 0) xb = 0;
          if (yb < 0) yb = 0;
        end
      end
      CMD_RECT: begin
        if (big_rects < 3 && $urandom_range(24) == 0) begin
          big_rects++;
        end else begin
          xb = $urandom_range(12);
          yb = $urandom_range(12);
        end
      end
      CMD_FILL: begin
        if ($urandom_range(7) != 0) begin
          xb = xa + $urandom_range(24);
          ya = $urandom_range(PAGE_COUNT + 1);
          yb = ya + $urandom_range(3);
        end
      end
      default: begin
      end
    endcase
    queue_cmd(cmd, xa, ya, xb, yb, pat);
  endtask

  task automatic wait_for_quiet();
    while (cmd_backlog.size() != 0 || cmd_if.valid || pending_replies.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    stall_request  = 1'b0;
    send_idle_pct  = 15;
    recv_idle_pct  = 76;
    foreach (frame_model[i]) frame_model[i] = '0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    queue_cmd(CMD_READ,    5,  5,   0,   0, 0);
    queue_cmd(CMD_SET_DOT, 0,  0,   0,   0, 0);
    queue_cmd(CMD_SET_DOT, 0,  0, 255, 127, 255);
    queue_cmd(CMD_READ,    0,  0,   0,   0, 0);
    queue_cmd(CMD_SET_DOT, 127, 63, 0,   0, 0);
    queue_cmd(CMD_READ,    127, 63, 0,   0, 0);
    queue_cmd(CMD_CLR_DOT, 127, 63, 0,   0, 0);
    queue_cmd(CMD_CLR_DOT, 127, 63, 0,   0, 0);
    queue_cmd(CMD_LINE,    10, 10,  10,  10, 0);
    queue_cmd(CMD_LINE,    100, 5,  20,  40, 0);
    queue_cmd(CMD_LINE,    3,  60,  50,   2, 0);
    queue_cmd(CMD_LINE,    0,   0, 128,   0, 0);
    queue_cmd(CMD_LINE,    60, 63, 255, 127, 0);
    queue_cmd(CMD_LINE,    5,   0,   5,  64, 0);
    queue_cmd(CMD_READ,    5,  40,   0,   0, 0);
    queue_cmd(CMD_RECT,    120, 60, 20,  10, 0);
    queue_cmd(CMD_RECT,    30, 30,   0,   5, 0);
    queue_cmd(CMD_RECT,    0,   0, 255, 127, 0);
    queue_cmd(CMD_READ,    77, 33,   0,   0, 0);
    queue_cmd(CMD_FILL,    0,   0, 255, 127, 8'h00);
    queue_cmd(CMD_FILL,    10,  2,  20,   4, 8'hA5);
    queue_cmd(CMD_FILL,    50,  0,  40,   8, 8'hFF);
    queue_cmd(CMD_FILL,    0,   6, 128,   6, 8'hFF);
    queue_cmd(CMD_READ,    15, 17,   0,   0, 0);
    queue_cmd(CMD_UNUSED_LO, 1, 1,   1,   1, 1);
    queue_cmd(CMD_UNUSED_HI, 127, 63, 255, 127, 255);
    wait_for_quiet();

    repeat (150) queue_random_cmd();
    wait_for_quiet();

    send_idle_pct = 76;
    recv_idle_pct = 15;
    repeat (150) queue_random_cmd();
    wait_for_quiet();

    // With no idling on either side, a long result stall backs the engine up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (40) queue_random_cmd();
    stall_request = 1'b1;
    @(negedge clk_i);
    stall_request = 1'b0;
    repeat (60) queue_random_cmd();
    wait_for_quiet();

    repeat (LATENCY_SLACK) @(negedge clk_i);

    $display("Covered %0d set dot, %0d clear dot, %0d line, %0d rectangle, %0d fill, %0d read",
             cmd_tally[CMD_SET_DOT], cmd_tally[CMD_CLR_DOT], cmd_tally[CMD_LINE],
             cmd_tally[CMD_RECT], cmd_tally[CMD_FILL], cmd_tally[CMD_READ]);
    $display("and %0d unused-code commands; %0d results checked, %0d mismatches, %0d long stalls.",
             cmd_tally[CMD_UNUSED_LO] + cmd_tally[CMD_UNUSED_HI], replies_checked,
             mismatch_count, long_stalls);
    if (mismatch_count == 0 && pending_replies.size() == 0) begin
      $display("page_framebuffer_draw_engine_unit verification clean");
    end else begin
      $display("page_framebuffer_draw_engine_unit verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hw/rtl/pfde_pkg.sv
hw/rtl/pfde_intf.sv
hw/rtl/page_framebuffer_draw_engine_unit.sv
tb/sv/tb_page_framebuffer_draw_engine_unit.sv
